>>> rtl/motor_fault_monitor_assert.svh
// Assertion macros for the motor fault monitor checkers.
// Each checker that uses them has clk_i and rst_ni in scope.
`ifndef MOTOR_FAULT_MONITOR_ASSERT_SVH
`define MOTOR_FAULT_MONITOR_ASSERT_SVH

// Property checked at every clock edge outside reset
`define MFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define MFM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mfm_pkg.sv
package mfm_pkg;

  // Motor count and field widths
  localparam int unsigned MaxMotorsDefault = 16;
  localparam int unsigned MotorW    = 4;
  localparam int unsigned CurrentW  = 17;
  localparam int unsigned TempW     = 16;
  localparam int unsigned PosW      = 32;
  localparam int unsigned TimeW     = 48;
  localparam int unsigned HbAgeW    = 32;
  localparam int unsigned CodeW     = 3;

  // Stream packing
  localparam int unsigned InDataW   = 152;
  localparam int unsigned InUserW   = 2;
  localparam int unsigned OutDataW  = 16;

  // Configuration port
  localparam int unsigned CfgAddrW  = 2;
  localparam int unsigned CfgDataW  = 16;
  localparam logic [CfgAddrW-1:0] RegOvercurrent = 2'd0;
  localparam logic [CfgAddrW-1:0] RegOvertemp    = 2'd1;
  localparam logic [CfgAddrW-1:0] RegStall       = 2'd2;
  localparam logic [CfgAddrW-1:0] RegHeartbeat   = 2'd3;

  // Stall limit kept in microseconds: 255 s fits in 28 bits
  localparam int unsigned StallUsW  = 28;
  localparam logic [19:0] UsPerSec  = 20'd1_000_000;

  // Fault codes
  localparam logic [CodeW-1:0] FaultNone        = 3'd0;
  localparam logic [CodeW-1:0] FaultOvercurrent = 3'd1;
  localparam logic [CodeW-1:0] FaultOvertemp    = 3'd2;
  localparam logic [CodeW-1:0] FaultStall       = 3'd3;
  localparam logic [CodeW-1:0] FaultHeartbeat   = 3'd4;

endpackage

>>> rtl/motor_fault_monitor.sv
// An accepted input beat passes through the input stage and the result register to m_axis.
// Throughput: one beat per cycle when m_axis is not stalled; the per-motor state is
// read and written in the input stage, so each beat sees what the previous one left.
// Reset (rst_ni low, asynchronous): limits, per-motor position and stall
// start, and the scan fault flag clear to zero; both stages go empty.
module motor_fault_monitor
  import mfm_pkg::*;
#(
  parameter int unsigned MAX_MOTORS = MaxMotorsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // tuser: command[0], has_feedback[1]
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: motor_index[3:0], current_ma[20:4], temperature_dc[36:21],
  //        encoder_position[68:37], time_us[116:69], heartbeat_age_ms[148:117]
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic [InUserW-1:0]  s_axis_tuser,
  // tdata: stop_request[0], fault_code[3:1], fault_motor[7:4], item_ignored[8]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Only 16 motors can be addressed by the index field
  localparam int unsigned Depth = (MAX_MOTORS < 16) ? MAX_MOTORS : 16;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  // Configuration registers
  logic [15:0]         oc_lim_q;
  logic [7:0]          ot_lim_q;
  logic [StallUsW-1:0] stall_lim_us_q;
  logic [15:0]         hb_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oc_lim_q       <= '0;
      ot_lim_q       <= '0;
      stall_lim_us_q <= '0;
      hb_lim_q       <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        RegOvercurrent: oc_lim_q <= cfg_data_i;
        RegOvertemp:    ot_lim_q <= cfg_data_i[7:0];
        RegStall:       stall_lim_us_q <= StallUsW'(cfg_data_i[7:0]) * StallUsW'(UsPerSec);
        RegHeartbeat:   hb_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage
  logic                s1_valid_q;
  logic                cmd_q, has_fb_q;
  logic [MotorW-1:0]   motor_q;
  logic [CurrentW-1:0] cur_q;
  logic [TempW-1:0]    temp_q;
  logic [PosW-1:0]     pos_q;
  logic [TimeW-1:0]    now_q;
  logic [HbAgeW-1:0]   hb_age_q;
  logic                s1_adv;

  assign s1_adv        = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q    <= s_axis_tuser[0];
      has_fb_q <= s_axis_tuser[1];
      motor_q  <= s_axis_tdata[3:0];
      cur_q    <= s_axis_tdata[20:4];
      temp_q   <= s_axis_tdata[36:21];
      pos_q    <= s_axis_tdata[68:37];
      now_q    <= s_axis_tdata[116:69];
      hb_age_q <= s_axis_tdata[148:117];
    end
  end

  // Per-motor stall tracking state and scan flag
  logic [PosW-1:0]  last_pos_q [Depth];
  logic [TimeW-1:0] stall_start_q [Depth];
  logic             scan_faulted_q, scan_faulted_d;

  logic [IdxW-1:0]  idx;
  logic             in_range;
  logic [PosW-1:0]  last_pos;
  logic [TimeW-1:0] stall_start;
  logic [TimeW-1:0] elapsed;
  logic [11:0]      ot_lim_x10;
  logic             oc_hit, ot_hit, hb_hit;
  logic             wr_pos, wr_start;

  assign idx         = IdxW'(motor_q);
  assign in_range    = {5'd0, motor_q} < 9'(Depth);
  assign last_pos    = last_pos_q[idx];
  assign stall_start = stall_start_q[idx];
  assign elapsed     = now_q - stall_start;
  assign ot_lim_x10  = {1'b0, ot_lim_q, 3'b000} + {3'b000, ot_lim_q, 1'b0};

  assign oc_hit = (oc_lim_q != '0) && ($signed({cur_q[CurrentW-1], cur_q})
                  > $signed({2'b00, oc_lim_q}));
  assign ot_hit = (ot_lim_q != '0) && ($signed({temp_q[TempW-1], temp_q})
                  > $signed({5'b00000, ot_lim_x10}));
  assign hb_hit = (hb_lim_q != '0) && (hb_age_q > {16'd0, hb_lim_q});

  // Result fields of the item in the input stage
  logic              stop_d, ign_d;
  logic [CodeW-1:0]  code_d;
  logic [MotorW-1:0] fmotor_d;

  always_comb begin
    stop_d         = 1'b0;
    ign_d          = 1'b0;
    code_d         = FaultNone;
    fmotor_d       = '0;
    scan_faulted_d = scan_faulted_q;
    wr_pos         = 1'b0;
    wr_start       = 1'b0;
    if (cmd_q) begin
      // End of scan: heartbeat check unless already faulted, then re-arm
      if (scan_faulted_q) begin
        ign_d          = 1'b1;
        scan_faulted_d = 1'b0;
      end else if (hb_hit) begin
        stop_d = 1'b1;
        code_d = FaultHeartbeat;
      end
    end else if (scan_faulted_q || !has_fb_q || !in_range) begin
      ign_d = 1'b1;
    end else if (oc_hit) begin
      stop_d         = 1'b1;
      code_d         = FaultOvercurrent;
      fmotor_d       = motor_q;
      scan_faulted_d = 1'b1;
    end else if (ot_hit) begin
      stop_d         = 1'b1;
      code_d         = FaultOvertemp;
      fmotor_d       = motor_q;
      scan_faulted_d = 1'b1;
    end else if (stall_lim_us_q != '0) begin
      if (pos_q != last_pos) begin
        wr_pos = 1'b1;
      end else if (stall_start == '0) begin
        wr_start = 1'b1;
      end else if (elapsed > {20'd0, stall_lim_us_q}) begin
        stop_d         = 1'b1;
        code_d         = FaultStall;
        fmotor_d       = motor_q;
        scan_faulted_d = 1'b1;
      end
    end
  end

  // State update, taken when the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_faulted_q <= 1'b0;
      for (int i = 0; i < Depth; i++) begin
        last_pos_q[i]    <= '0;
        stall_start_q[i] <= '0;
      end
    end else if (s1_adv) begin
      scan_faulted_q <= scan_faulted_d;
      if (wr_pos) begin
        last_pos_q[idx]    <= pos_q;
        stall_start_q[idx] <= '0;
      end else if (wr_start) begin
        stall_start_q[idx] <= now_q;
      end
    end
  end

  // Result register
  logic              out_valid_q;
  logic              stop_q, ign_q;
  logic [CodeW-1:0]  code_q;
  logic [MotorW-1:0] fmotor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      stop_q   <= stop_d;
      code_q   <= code_d;
      fmotor_q <= fmotor_d;
      ign_q    <= ign_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, ign_q, fmotor_q, code_q, stop_q};

endmodule

>>> rtl/motor_fault_monitor_checker.sv
`include "motor_fault_monitor_assert.svh"

module motor_fault_monitor_checker
  import mfm_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic              stop;
  logic              ign;
  logic [CodeW-1:0]  code;
  logic [MotorW-1:0] fmotor;

  assign stop   = m_axis_tdata[0];
  assign code   = m_axis_tdata[3:1];
  assign fmotor = m_axis_tdata[7:4];
  assign ign    = m_axis_tdata[8];

  // A stalled result beat holds
  `MFM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

  // Stop request goes with a fault code and never with an ignored item
  `MFM_ASSERT(a_stop_code, !m_axis_tvalid || (stop == (code != FaultNone)) && !(stop && ign),
              "stop request and fault code disagree")

  // No motor is named for a heartbeat fault or for no fault
  `MFM_ASSERT(a_motor_zero, !m_axis_tvalid || !((code == FaultNone) ||
              (code == FaultHeartbeat)) || (fmotor == '0), "fault motor set without motor fault")

endmodule

bind motor_fault_monitor motor_fault_monitor_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> tb/tb_motor_fault_monitor.sv
module tb_motor_fault_monitor;
  import mfm_pkg::*;

  localparam int unsigned CycleLimit = 200_000;

  // One input beat, fields in tdata order from the top down
  typedef struct packed {
    logic                command;
    logic                has_feedback;
    logic [MotorW-1:0]   motor;
    logic [CurrentW-1:0] current_ma;
    logic [TempW-1:0]    temp_dc;
    logic [PosW-1:0]     position;
    logic [TimeW-1:0]    time_us;
    logic [HbAgeW-1:0]   hb_age_ms;
  } sample_t;

  // One result beat
  typedef struct packed {
    logic              stop;
    logic [CodeW-1:0]  code;
    logic [MotorW-1:0] motor;
    logic              ignored;
  } verdict_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // tdata: motor_index, current_ma, temperature_dc, encoder_position, time_us,
  //        heartbeat_age_ms (lowest bits first)
  logic [InDataW-1:0]  s_axis_tdata = '0;
  // tuser: command, has_feedback (lowest bit first)
  logic [InUserW-1:0]  s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // tdata: stop_request, fault_code, fault_motor, item_ignored (lowest bits first)
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Supervisor copy: limits, per-motor tracking, scan fault flag
  logic [15:0]      oc_limit_ma = '0;
  logic [7:0]       ot_limit_c = '0;
  logic [7:0]       stall_limit_s = '0;
  logic [15:0]      hb_limit_ms = '0;
  logic [PosW-1:0]  pos_seen [MaxMotorsDefault] = '{default: '0};
  logic [TimeW-1:0] still_since_us [MaxMotorsDefault] = '{default: '0};
  logic             scan_tripped = 1'b0;

  verdict_t    pending_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_items = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Stimulus-side tracking for well-formed scans
  logic [TimeW-1:0] scan_clock_us = '0;
  logic [PosW-1:0]  driven_pos [MaxMotorsDefault] = '{default: '0};

  motor_fault_monitor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("motor_fault_monitor test failed");
      $finish;
    end
  end

  // Result side backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Expected verdict for one sample; updates the supervisor copy
  function automatic verdict_t predict_verdict(sample_t s);
    verdict_t         v;
    int               cur;
    int               tmp;
    logic [TimeW-1:0] elapsed;
    longint unsigned  allowed_us;
    v = '0;
    v.code = FaultNone;
    // End of scan: re-arm, or check heartbeat
    if (s.command) begin
      if (scan_tripped) begin
        scan_tripped = 1'b0;
        v.ignored = 1'b1;
      end else if (hb_limit_ms != 0 && s.hb_age_ms > hb_limit_ms) begin
        v.stop = 1'b1;
        v.code = FaultHeartbeat;
      end
      return v;
    end
    if (scan_tripped || !s.has_feedback || s.motor >= MaxMotorsDefault) begin
      v.ignored = 1'b1;
      return v;
    end
    cur = int'($signed(s.current_ma));
    tmp = int'($signed(s.temp_dc));
    if (oc_limit_ma != 0 && cur > int'(oc_limit_ma)) begin
      v.code = FaultOvercurrent;
    end else if (ot_limit_c != 0 && tmp > int'(ot_limit_c) * 10) begin
      v.code = FaultOvertemp;
    end else if (stall_limit_s != 0) begin
      // Stall tracking; a start of zero reads as not stalling
      if (s.position == pos_seen[s.motor]) begin
        if (still_since_us[s.motor] == '0) begin
          still_since_us[s.motor] = s.time_us;
        end else begin
          elapsed = s.time_us - still_since_us[s.motor];
          allowed_us = 64'(stall_limit_s) * 64'd1_000_000;
          if (64'(elapsed) > allowed_us) v.code = FaultStall;
        end
      end else begin
        pos_seen[s.motor] = s.position;
        still_since_us[s.motor] = '0;
      end
    end
    if (v.code != FaultNone) begin
      scan_tripped = 1'b1;
      v.stop = 1'b1;
      v.motor = s.motor;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatches++;
    // keep the log readable on a badly broken build
    if (mismatches <= 100)
      $display("MISMATCH %s: expected %0d got %0d at cycle %0d", what, want, got,
               cycle_count);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    verdict_t want;
    verdict_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.stop    = m_axis_tdata[0];
      got.code    = m_axis_tdata[3:1];
      got.motor   = m_axis_tdata[7:4];
      got.ignored = m_axis_tdata[8];
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 32'(m_axis_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        if (got.stop != want.stop)
          report_mismatch("stop_request", 32'(want.stop), 32'(got.stop));
        if (got.code != want.code)
          report_mismatch("fault_code", 32'(want.code), 32'(got.code));
        if (got.motor != want.motor)
          report_mismatch("fault_motor", 32'(want.motor), 32'(got.motor));
        if (got.ignored != want.ignored)
          report_mismatch("item_ignored", 32'(want.ignored), 32'(got.ignored));
      end
    end
  end

  // Drive one beat, wait for the handshake, queue its verdict
  task automatic send_sample(sample_t s);
    verdict_t want;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InDataW'({s.hb_age_ms, s.time_us, s.position, s.temp_dc,
                               s.current_ma, s.motor});
    s_axis_tuser  <= {s.has_feedback, s.command};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    want = predict_verdict(s);
    sent_items++;
    pending_verdicts.push_back(want);
  endtask

  // Hold off the sender until every verdict is back
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CfgAddrW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegOvercurrent: oc_limit_ma = val;
      RegOvertemp:    ot_limit_c = val[7:0];
      RegStall:       stall_limit_s = val[7:0];
      RegHeartbeat:   hb_limit_ms = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [15:0] oc, logic [15:0] ot, logic [15:0] st,
                           logic [15:0] hb);
    wait_drained();
    write_limit(RegOvercurrent, oc);
    write_limit(RegOvertemp, ot);
    write_limit(RegStall, st);
    write_limit(RegHeartbeat, hb);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [TimeW-1:0] rand_time48();
    return {16'($urandom_range(16'hFFFF)), $urandom};
  endfunction

  function automatic sample_t rand_noise();
    sample_t s;
    s.command      = 1'($urandom_range(1));
    s.has_feedback = 1'($urandom_range(1));
    s.motor        = 4'($urandom_range(15));
    s.current_ma   = 17'($urandom_range(17'h1FFFF));
    s.temp_dc      = 16'($urandom_range(16'hFFFF));
    s.position     = $urandom;
    s.time_us      = rand_time48();
    s.hb_age_ms    = $urandom;
    return s;
  endfunction

  function automatic sample_t fb_sample(logic [MotorW-1:0] m, int cur, int tmp,
                                        logic [PosW-1:0] pos, logic [TimeW-1:0] t);
    sample_t s;
    s = '0;
    s.has_feedback = 1'b1;
    s.motor        = m;
    s.current_ma   = cur[CurrentW-1:0];
    s.temp_dc      = tmp[TempW-1:0];
    s.position     = pos;
    s.time_us      = t;
    return s;
  endfunction

  function automatic sample_t scan_end(logic [HbAgeW-1:0] hb);
    sample_t s;
    s = '0;
    s.command   = 1'b1;
    s.hb_age_ms = hb;
    return s;
  endfunction

  // Current mostly below the limit, some at the edge, some anywhere
  function automatic logic [CurrentW-1:0] pick_current();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 70) v = $urandom_range(oc_limit_ma == 0 ? 65535 : oc_limit_ma);
    else if (r < 80) v = -int'($urandom_range(65536));
    else if (r < 88) v = int'(oc_limit_ma) + $urandom_range(1);
    else v = $urandom;
    return v[CurrentW-1:0];
  endfunction

  function automatic logic [TempW-1:0] pick_temp();
    int r;
    int lim10;
    int v;
    r = $urandom_range(99);
    lim10 = (ot_limit_c == 0) ? 32767 : int'(ot_limit_c) * 10;
    if (r < 75) v = $urandom_range(lim10);
    else if (r < 85) v = -int'($urandom_range(32768));
    else if (r < 92) v = lim10 + $urandom_range(1);
    else v = $urandom;
    return v[TempW-1:0];
  endfunction

  function automatic logic [HbAgeW-1:0] pick_hb_age();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(hb_limit_ms == 0 ? 65535 : hb_limit_ms);
    if (r < 90) return 32'(hb_limit_ms) + $urandom_range(1);
    return $urandom;
  endfunction

  function automatic logic [15:0] rand_limit();
    if ($urandom_range(99) < 20) return '0;
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // Scans of a few samples each, closed by an end-of-scan beat, with noise mixed in
  task automatic run_scans(int unsigned n_items);
    int unsigned       start;
    int unsigned       count;
    int unsigned       r;
    sample_t           s;
    logic [MotorW-1:0] m;
    start = sent_items;
    while (sent_items - start < n_items) begin
      if ($urandom_range(99) < 2) wait_drained();
      if ($urandom_range(99) < 10) begin
        send_sample(rand_noise());
      end else begin
        // advance the scan time; jumps near the stall limit hit its edge
        r = $urandom_range(99);
        if (r < 4) scan_clock_us = rand_time48();
        else if (r < 12)
          scan_clock_us = scan_clock_us + 48'(stall_limit_s) * 1_000_000
                          + $urandom_range(2);
        else scan_clock_us = scan_clock_us + $urandom_range(1_500_000);
        count = $urandom_range(6, 1);
        repeat (count) begin
          m = 4'($urandom_range(15));
          s = rand_noise();
          s.command      = 1'b0;
          s.motor        = m;
          s.has_feedback = ($urandom_range(99) < 92);
          s.time_us      = scan_clock_us;
          s.current_ma   = pick_current();
          s.temp_dc      = pick_temp();
          if ($urandom_range(99) < 75) begin
            s.position = driven_pos[m];
          end else begin
            s.position = $urandom;
            driven_pos[m] = s.position;
          end
          send_sample(s);
        end
        s = rand_noise();
        s.command   = 1'b1;
        s.hb_age_ms = pick_hb_age();
        send_sample(s);
      end
    end
  endtask

  // All limits at reset (zero): nothing may fault, field extremes pass through
  task automatic test_limits_disabled();
    sample_t s;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_sample(fb_sample(4'd0, 65535, 32767, 32'h8000_0000, '1));
    send_sample(fb_sample(4'd15, -65536, -32768, 32'h7FFF_FFFF, '0));
    send_sample(fb_sample(4'd15, -65536, -32768, 32'h7FFF_FFFF, 48'd5));
    s = fb_sample(4'd3, 65535, 32767, '0, '0);
    s.has_feedback = 1'b0;
    send_sample(s);
    send_sample(scan_end('1));
  endtask

  task automatic test_directed_faults();
    sample_t s;
    configure(16'd1000, 16'd50, 16'd1, 16'd100);
    // limits at their edge pass, one above trips; rest of the scan skipped
    send_sample(fb_sample(4'd0, 1000, 500, 32'd5, 48'd1000));
    s = fb_sample(4'd1, 65535, 32767, '0, 48'd1000);
    s.has_feedback = 1'b0;
    send_sample(s);
    send_sample(fb_sample(4'd2, 1001, 0, '0, 48'd1000));
    send_sample(fb_sample(4'd3, 0, 0, '0, 48'd1000));
    send_sample(scan_end(32'd5000));
    send_sample(fb_sample(4'd4, 0, 501, '0, 48'd2000));
    send_sample(scan_end('0));
    // heartbeat edge and extreme
    send_sample(scan_end(32'd100));
    send_sample(scan_end(32'd101));
    send_sample(scan_end('1));
    // stall after more than one second unchanged
    send_sample(fb_sample(4'd0, 0, 0, 32'd5, 48'd2_000_000));
    send_sample(fb_sample(4'd0, 0, 0, 32'd5, 48'd3_000_001));
    send_sample(scan_end('0));
    // stall start stored at time zero still reads as not stalling
    send_sample(fb_sample(4'd5, 0, 0, 32'd7, '0));
    send_sample(fb_sample(4'd5, 0, 0, 32'd7, '0));
    send_sample(fb_sample(4'd5, 0, 0, 32'd7, 48'd5_000_000));
    send_sample(fb_sample(4'd5, 0, 0, 32'd7, 48'd6_000_001));
    send_sample(scan_end('0));
    // elapsed time wraps at 2^48
    send_sample(fb_sample(4'd6, 0, 0, '1, 48'hFFFF_FFFF_FFF6));
    send_sample(fb_sample(4'd6, 0, 0, '1, 48'hFFFF_FFFF_FFF6));
    send_sample(fb_sample(4'd6, 0, 0, '1, 48'd999_990));
    send_sample(fb_sample(4'd6, 0, 0, '1, 48'd1_000_000));
    send_sample(scan_end('0));
  endtask

  task automatic test_no_idling();
    configure(16'd1000, 16'd60, 16'd1, 16'd200);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_scans(250);
  endtask

  task automatic test_sender_gaps();
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_idle_pct = 71;
    recv_stall_pct = 0;
    run_scans(200);
  endtask

  task automatic test_receiver_stalls();
    configure(16'd1, 16'd1, 16'd1, 16'd1);
    send_idle_pct = 0;
    recv_stall_pct = 71;
    run_scans(200);
  endtask

  task automatic test_both_idle();
    configure(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
              16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
    send_idle_pct = 13;
    recv_stall_pct = 13;
    run_scans(250);
  endtask

  task automatic test_limits_random();
    configure('0, '0, '0, '0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_scans(40);
    repeat (3) begin
      configure(rand_limit(), rand_limit(), rand_limit(), rand_limit());
      run_scans(25);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_limits_disabled();
    test_directed_faults();
    test_no_idling();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_limits_random();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("motor_fault_monitor test passed");
    end else begin
      $display("motor_fault_monitor test failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mfm_pkg.sv
rtl/motor_fault_monitor.sv
rtl/motor_fault_monitor_checker.sv
tb/tb_motor_fault_monitor.sv
